@@ design/mlr_pkg.sv @@
// package for the midpoint line rasterizer: default sizes, controller state,
// command and status words shared by controller, datapath and top level
// no dependencies
package mlr_pkg;

  localparam int COORD_BITS_DEF      = 6;
  localparam int DEPTH_BITS_DEF      = 8;
  localparam int COLOR_BITS_DEF      = 8;
  localparam int COLOR_FRAC_BITS_DEF = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQ_Z,
    ST_SQ_SUM,
    ST_N_MUL,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_SQRT_LOAD,
    ST_SQRT_RUN,
    ST_STEP_WR,
    ST_WALK
  } state_t;

  typedef enum logic [1:0] {
    MUL_A,
    MUL_B,
    MUL_Z,
    MUL_N
  } mul_sel_t;

  typedef enum logic [1:0] {
    CLS_1,
    CLS_2,
    CLS_3,
    CLS_4
  } cls_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     div_init;
    logic     div_step;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     step_wr;
    logic [1:0] chan;
    logic     pix;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

@@ design/midpoint_line_raster_top.sv @@
// midpoint line rasterizer with color interpolation, top level
// setup computes the squared length, then runs the bit-serial divider and square root
// once per channel
// throughput: after setup, one pixel per cycle while out_ready holds, up to 2^COORD_BITS pixels
// a new segment is taken once the last pixel word is loaded into the output register
// rst is synchronous: controller returns to idle and out_valid drops
module midpoint_line_raster_top #(
  parameter int COORD_BITS      = mlr_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS      = mlr_pkg::DEPTH_BITS_DEF,
  parameter int COLOR_BITS      = mlr_pkg::COLOR_BITS_DEF,
  parameter int COLOR_FRAC_BITS = mlr_pkg::COLOR_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [DEPTH_BITS-1:0] start_z,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [DEPTH_BITS-1:0] end_z,
  input  logic [COLOR_BITS-1:0] start_red,
  input  logic [COLOR_BITS-1:0] start_green,
  input  logic [COLOR_BITS-1:0] start_blue,
  input  logic [COLOR_BITS-1:0] end_red,
  input  logic [COLOR_BITS-1:0] end_green,
  input  logic [COLOR_BITS-1:0] end_blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_BITS-1:0] pixel_red,
  output logic [COLOR_BITS-1:0] pixel_green,
  output logic [COLOR_BITS-1:0] pixel_blue,
  output logic                  last_pixel
);

  mlr_pkg::dp_cmd_t    cmd;
  mlr_pkg::dp_status_t status;

  mlr_ctrl #(
    .COLOR_BITS      (COLOR_BITS),
    .COLOR_FRAC_BITS (COLOR_FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  mlr_dp #(
    .COORD_BITS      (COORD_BITS),
    .DEPTH_BITS      (DEPTH_BITS),
    .COLOR_BITS      (COLOR_BITS),
    .COLOR_FRAC_BITS (COLOR_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .start_x     (start_x),
    .start_y     (start_y),
    .start_z     (start_z),
    .end_x       (end_x),
    .end_y       (end_y),
    .end_z       (end_z),
    .start_red   (start_red),
    .start_green (start_green),
    .start_blue  (start_blue),
    .end_red     (end_red),
    .end_green   (end_green),
    .end_blue    (end_blue),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .last_pixel  (last_pixel)
  );

  // busy right after a segment is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after accept");

  // no pixel word produced while idle
  a_no_pixel_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.pix)
    else $error("pixel produced while idle");

  // back to idle right after the last pixel word is loaded
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.pix && status.last) |=> in_ready)
    else $error("not idle after last pixel");

  // a loaded pixel word is always shown as valid
  a_valid_after_pixel: assert property (@(posedge clk) disable iff (rst)
    cmd.pix |=> out_valid)
    else $error("pixel loaded without out_valid");

endmodule

@@ design/mlr_ctrl.sv @@
// controller for the midpoint line rasterizer: sequences length, division,
// square root per channel and the pixel walk; owns the output valid flag
// depends on mlr_pkg
module mlr_ctrl #(
  parameter int COLOR_BITS      = mlr_pkg::COLOR_BITS_DEF,
  parameter int COLOR_FRAC_BITS = mlr_pkg::COLOR_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output mlr_pkg::dp_cmd_t    cmd,
  input  mlr_pkg::dp_status_t status
);

  localparam int NW     = COLOR_BITS + COLOR_FRAC_BITS;
  localparam int DIV_N  = 2 * NW;
  localparam int ITER_W = $clog2(DIV_N + 1);

  mlr_pkg::state_t state, state_next;
  logic [ITER_W-1:0] iter;
  logic [1:0]        chan;
  logic              pix;

  assign in_ready = (state == mlr_pkg::ST_IDLE);
  assign pix      = (state == mlr_pkg::ST_WALK) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      mlr_pkg::ST_IDLE:      if (in_valid) state_next = mlr_pkg::ST_SQ_A;
      mlr_pkg::ST_SQ_A:      state_next = mlr_pkg::ST_SQ_B;
      mlr_pkg::ST_SQ_B:      state_next = mlr_pkg::ST_SQ_Z;
      mlr_pkg::ST_SQ_Z:      state_next = mlr_pkg::ST_SQ_SUM;
      mlr_pkg::ST_SQ_SUM:    state_next = mlr_pkg::ST_N_MUL;
      mlr_pkg::ST_N_MUL:     state_next = mlr_pkg::ST_DIV_LOAD;
      mlr_pkg::ST_DIV_LOAD:  state_next = mlr_pkg::ST_DIV_RUN;
      mlr_pkg::ST_DIV_RUN:
        if (iter == ITER_W'(DIV_N - 1)) state_next = mlr_pkg::ST_SQRT_LOAD;
      mlr_pkg::ST_SQRT_LOAD: state_next = mlr_pkg::ST_SQRT_RUN;
      mlr_pkg::ST_SQRT_RUN:
        if (iter == ITER_W'(NW - 1)) state_next = mlr_pkg::ST_STEP_WR;
      mlr_pkg::ST_STEP_WR:
        state_next = (chan == 2'd2) ? mlr_pkg::ST_WALK : mlr_pkg::ST_N_MUL;
      mlr_pkg::ST_WALK:
        if (pix && status.last) state_next = mlr_pkg::ST_IDLE;
      default:               state_next = mlr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = mlr_pkg::MUL_A;
    cmd.chan    = chan;
    unique case (state)
      mlr_pkg::ST_IDLE:      cmd.load = in_valid;
      mlr_pkg::ST_SQ_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mlr_pkg::MUL_A;
      end
      mlr_pkg::ST_SQ_B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mlr_pkg::MUL_B;
        cmd.acc_en  = 1'b1;
      end
      mlr_pkg::ST_SQ_Z: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mlr_pkg::MUL_Z;
        cmd.acc_en  = 1'b1;
      end
      mlr_pkg::ST_SQ_SUM:    cmd.acc_en = 1'b1;
      mlr_pkg::ST_N_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mlr_pkg::MUL_N;
      end
      mlr_pkg::ST_DIV_LOAD:  cmd.div_init  = 1'b1;
      mlr_pkg::ST_DIV_RUN:   cmd.div_step  = 1'b1;
      mlr_pkg::ST_SQRT_LOAD: cmd.sqrt_init = 1'b1;
      mlr_pkg::ST_SQRT_RUN:  cmd.sqrt_step = 1'b1;
      mlr_pkg::ST_STEP_WR:   cmd.step_wr   = 1'b1;
      mlr_pkg::ST_WALK:      cmd.pix       = pix;
      default:               cmd.load      = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mlr_pkg::ST_IDLE;
      iter      <= '0;
      chan      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mlr_pkg::ST_DIV_RUN || state == mlr_pkg::ST_SQRT_RUN) begin
        iter <= (state_next == state) ? iter + 1'b1 : '0;
      end else begin
        iter <= '0;
      end
      if (state == mlr_pkg::ST_IDLE) begin
        chan <= '0;
      end else if (state == mlr_pkg::ST_STEP_WR) begin
        chan <= chan + 1'b1;
      end
      if (pix) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/mlr_dp.sv @@
// datapath for the midpoint line rasterizer: endpoint ordering, length by a
// shared multiplier, bit-serial divider and square root, pixel walk and color
// depends on mlr_pkg
module mlr_dp #(
  parameter int COORD_BITS      = mlr_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS      = mlr_pkg::DEPTH_BITS_DEF,
  parameter int COLOR_BITS      = mlr_pkg::COLOR_BITS_DEF,
  parameter int COLOR_FRAC_BITS = mlr_pkg::COLOR_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mlr_pkg::dp_cmd_t           cmd,
  output mlr_pkg::dp_status_t        status,
  input  logic [COORD_BITS-1:0]      start_x,
  input  logic [COORD_BITS-1:0]      start_y,
  input  logic [DEPTH_BITS-1:0]      start_z,
  input  logic [COORD_BITS-1:0]      end_x,
  input  logic [COORD_BITS-1:0]      end_y,
  input  logic [DEPTH_BITS-1:0]      end_z,
  input  logic [COLOR_BITS-1:0]      start_red,
  input  logic [COLOR_BITS-1:0]      start_green,
  input  logic [COLOR_BITS-1:0]      start_blue,
  input  logic [COLOR_BITS-1:0]      end_red,
  input  logic [COLOR_BITS-1:0]      end_green,
  input  logic [COLOR_BITS-1:0]      end_blue,
  output logic [COORD_BITS-1:0]      pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic [COLOR_BITS-1:0]      pixel_red,
  output logic [COLOR_BITS-1:0]      pixel_green,
  output logic [COLOR_BITS-1:0]      pixel_blue,
  output logic                       last_pixel
);

  localparam int CW  = COORD_BITS;
  localparam int ZW  = DEPTH_BITS;
  localparam int F   = COLOR_FRAC_BITS;
  localparam int NW  = COLOR_BITS + COLOR_FRAC_BITS;
  localparam int DW  = CW + 4;
  localparam int MW  = (NW > CW) ? ((NW > ZW) ? NW : ZW) : ((CW > ZW) ? CW : ZW);
  localparam int LW  = 2 * MW + 2;
  localparam int QW  = 2 * NW;
  localparam int SW  = NW + 1;
  localparam int VW  = NW + 2;

  // endpoint ordering and walk setup
  logic                 swap;
  logic [CW-1:0]        x0, y0, x1, y1;
  logic [ZW-1:0]        z0, z1;
  logic signed [DW-1:0] a_n, b_n, dec_n, cnt_w;
  logic signed [ZW:0]   dz_n;
  logic signed [DW-1:0] a_abs, b_abs;
  mlr_pkg::cls_t        cls_n;

  assign swap = start_x > end_x;
  assign x0 = swap ? end_x   : start_x;
  assign y0 = swap ? end_y   : start_y;
  assign z0 = swap ? end_z   : start_z;
  assign x1 = swap ? start_x : end_x;
  assign y1 = swap ? start_y : end_y;
  assign z1 = swap ? start_z : end_z;

  assign a_n  = $signed({{(DW-CW){1'b0}}, y1}) - $signed({{(DW-CW){1'b0}}, y0});
  assign b_n  = $signed({{(DW-CW){1'b0}}, x0}) - $signed({{(DW-CW){1'b0}}, x1});
  assign dz_n = $signed({1'b0, z1}) - $signed({1'b0, z0});
  assign a_abs = (a_n < 0) ? -a_n : a_n;
  assign b_abs = (b_n < 0) ? -b_n : b_n;

  always_comb begin
    priority if (a_n <= b_n) begin
      cls_n = mlr_pkg::CLS_1;
      dec_n = a_n - (b_n <<< 1);
      cnt_w = -a_n + DW'(1);
    end else if (a_n <= 0) begin
      cls_n = mlr_pkg::CLS_2;
      dec_n = (a_n <<< 1) - b_n;
      cnt_w = -b_n + DW'(1);
    end else if (a_n <= -b_n) begin
      cls_n = mlr_pkg::CLS_3;
      dec_n = (a_n <<< 1) + b_n;
      cnt_w = -b_n + DW'(1);
    end else begin
      cls_n = mlr_pkg::CLS_4;
      dec_n = a_n + (b_n <<< 1);
      cnt_w = a_n + DW'(1);
    end
  end

  logic [CW-1:0]        walk_x, walk_y;
  logic signed [DW-1:0] decision, a_r, b_r;
  mlr_pkg::cls_t        cls;
  logic [CW:0]          steps_left;
  logic [CW-1:0]        a_mag, b_mag;
  logic [ZW-1:0]        z_mag;
  logic [COLOR_BITS-1:0] c0 [3];
  logic [COLOR_BITS-1:0] c1 [3];

  // shared multiplier and squared length
  logic [MW-1:0]   mul_op;
  logic [2*MW-1:0] prod;
  logic [LW-1:0]   len2;
  logic [COLOR_BITS-1:0] cs, ce, dmag;
  logic            neg;
  logic [NW-1:0]   n_mag;

  assign cs    = c0[cmd.chan];
  assign ce    = c1[cmd.chan];
  assign neg   = ce < cs;
  assign dmag  = neg ? cs - ce : ce - cs;
  assign n_mag = {dmag, {F{1'b0}}};

  always_comb begin
    unique case (cmd.mul_sel)
      mlr_pkg::MUL_A: mul_op = MW'(a_mag);
      mlr_pkg::MUL_B: mul_op = MW'(b_mag);
      mlr_pkg::MUL_Z: mul_op = MW'(z_mag);
      mlr_pkg::MUL_N: mul_op = MW'(n_mag);
      default:        mul_op = '0;
    endcase
  end

  // restoring divider, quotient shifts into the dividend register
  logic [QW-1:0] div_num;
  logic [LW:0]   div_rem, div_sh;
  logic          div_ge;

  assign div_sh = {div_rem[LW-1:0], div_num[QW-1]};
  assign div_ge = div_sh >= {1'b0, len2};

  // digit-by-digit square root, two radicand bits a step
  logic [QW-1:0] sq_rad;
  logic [NW+1:0] sq_rem, sq_sh, sq_trial;
  logic [NW-1:0] sq_root;
  logic          sq_ge;

  assign sq_sh    = {sq_rem[NW-1:0], sq_rad[QW-1:QW-2]};
  assign sq_trial = {sq_root, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  logic signed [SW-1:0] color_step [3];
  logic [NW-1:0]        color_accum [3];
  logic [NW-1:0]        accum_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [VW-1:0] v;
      v = $signed({2'b00, color_accum[i]}) + VW'(color_step[i]);
      if (v < 0) begin
        accum_next[i] = '0;
      end else if (v[VW-1:NW] != 2'b00) begin
        accum_next[i] = '1;
      end else begin
        accum_next[i] = v[NW-1:0];
      end
    end
  end

  // midpoint step
  logic                 dge, dle;
  logic signed [DW-1:0] two_amb, two_apb, two_a, two_b;
  logic signed [DW-1:0] decision_next;
  logic [CW-1:0]        walk_x_next, walk_y_next;

  assign dge     = decision >= 0;
  assign dle     = decision <= 0;
  assign two_amb = (a_r - b_r) <<< 1;
  assign two_apb = (a_r + b_r) <<< 1;
  assign two_a   = a_r <<< 1;
  assign two_b   = b_r <<< 1;

  always_comb begin
    walk_x_next   = walk_x;
    walk_y_next   = walk_y;
    decision_next = decision;
    unique case (cls)
      mlr_pkg::CLS_1: begin
        if (dge) begin
          walk_x_next   = walk_x + 1'b1;
          decision_next = decision + two_amb;
        end else begin
          decision_next = decision - two_b;
        end
        walk_y_next = walk_y - 1'b1;
      end
      mlr_pkg::CLS_2: begin
        if (dle) begin
          walk_y_next   = walk_y - 1'b1;
          decision_next = decision + two_amb;
        end else begin
          decision_next = decision + two_a;
        end
        walk_x_next = walk_x + 1'b1;
      end
      mlr_pkg::CLS_3: begin
        if (dge) begin
          walk_y_next   = walk_y + 1'b1;
          decision_next = decision + two_apb;
        end else begin
          decision_next = decision + two_a;
        end
        walk_x_next = walk_x + 1'b1;
      end
      default: begin
        if (dle) begin
          walk_x_next   = walk_x + 1'b1;
          decision_next = decision + two_apb;
        end else begin
          decision_next = decision + two_b;
        end
        walk_y_next = walk_y + 1'b1;
      end
    endcase
  end

  assign status.last = (steps_left == (CW+1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
    end else if (cmd.load) begin
      steps_left <= cnt_w[CW:0];
    end else if (cmd.pix) begin
      steps_left <= steps_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      walk_x   <= x0;
      walk_y   <= y0;
      decision <= dec_n;
      a_r      <= a_n;
      b_r      <= b_n;
      cls      <= cls_n;
      a_mag    <= a_abs[CW-1:0];
      b_mag    <= b_abs[CW-1:0];
      z_mag    <= (dz_n < 0) ? ZW'(-dz_n) : ZW'(dz_n);
      len2     <= '0;
      c0[0] <= swap ? end_red   : start_red;
      c0[1] <= swap ? end_green : start_green;
      c0[2] <= swap ? end_blue  : start_blue;
      c1[0] <= swap ? start_red   : end_red;
      c1[1] <= swap ? start_green : end_green;
      c1[2] <= swap ? start_blue  : end_blue;
      color_accum[0] <= {(swap ? end_red   : start_red),   {F{1'b0}}};
      color_accum[1] <= {(swap ? end_green : start_green), {F{1'b0}}};
      color_accum[2] <= {(swap ? end_blue  : start_blue),  {F{1'b0}}};
    end else if (cmd.pix) begin
      walk_x   <= walk_x_next;
      walk_y   <= walk_y_next;
      decision <= decision_next;
      for (int i = 0; i < 3; i++) begin
        color_accum[i] <= accum_next[i];
      end
      pixel_x     <= walk_x;
      pixel_y     <= walk_y;
      pixel_red   <= accum_next[0][NW-1:F];
      pixel_green <= accum_next[1][NW-1:F];
      pixel_blue  <= accum_next[2][NW-1:F];
      last_pixel  <= status.last;
    end
    if (cmd.mul_en) begin
      prod <= mul_op * mul_op;
    end
    if (cmd.acc_en) begin
      len2 <= len2 + LW'(prod);
    end
    if (cmd.div_init) begin
      div_num <= prod[QW-1:0];
      div_rem <= '0;
    end else if (cmd.div_step) begin
      div_num <= {div_num[QW-2:0], div_ge};
      div_rem <= div_ge ? div_sh - {1'b0, len2} : div_sh;
    end
    if (cmd.sqrt_init) begin
      sq_rad  <= div_num;
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sqrt_step) begin
      sq_rad  <= {sq_rad[QW-3:0], 2'b00};
      sq_rem  <= sq_ge ? sq_sh - sq_trial : sq_sh;
      sq_root <= {sq_root[NW-2:0], sq_ge};
    end
    if (cmd.step_wr) begin
      // zero length gives a zero step
      if (len2 == '0) begin
        color_step[cmd.chan] <= '0;
      end else if (neg) begin
        color_step[cmd.chan] <= -$signed({1'b0, sq_root});
      end else begin
        color_step[cmd.chan] <= $signed({1'b0, sq_root});
      end
    end
  end

endmodule
